FILE: sv/pnf_pkg.sv
// Shared constants, types and character codes of the printf-style number formatter.
`default_nettype none

package pnf_pkg;

    // Sizes of the number path, the field width and the digit store.
    localparam int WORD_BITS   = 32;
    localparam int MAX_WIDTH   = 32;
    localparam int DIGIT_SLOTS = 11;
    localparam int ARG_BITS    = 32;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 4;
    localparam int BASE_BITS   = 5;

    // The divider retires this many quotient bits per cycle.
    localparam int STEP_BITS     = 8;
    localparam int DIV_CYCLES    = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int Q_BITS        = DIV_CYCLES * STEP_BITS;
    localparam int STEP_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
    localparam int CNT_BITS   = $clog2(DIGIT_SLOTS + 1);
    localparam int IDX_BITS   = $clog2(DIGIT_SLOTS);
    localparam int CMP_BITS   = (WIDTH_BITS > CNT_BITS) ? WIDTH_BITS : CNT_BITS;

    // Number bases.
    localparam logic [BASE_BITS-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX = 5'd16;

    // Character codes.
    localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_X    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_C       = 8'h63;
    localparam logic [CHAR_BITS-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_BITS-1:0] CH_H       = 8'h68;
    localparam logic [CHAR_BITS-1:0] CH_I       = 8'h69;
    localparam logic [CHAR_BITS-1:0] CH_L       = 8'h6C;
    localparam logic [CHAR_BITS-1:0] CH_O       = 8'h6F;
    localparam logic [CHAR_BITS-1:0] CH_U       = 8'h75;
    localparam logic [CHAR_BITS-1:0] CH_X       = 8'h78;

    // Offsets that turn a digit value of ten or more into a letter.
    localparam logic [CHAR_BITS-1:0] UPPER_OFS = 8'h37;
    localparam logic [CHAR_BITS-1:0] LOWER_OFS = 8'h57;

    // Format parse phase.
    typedef enum logic [2:0] {
        PH_PLAIN   = 3'd0,
        PH_PERCENT = 3'd1,
        PH_FLAGGED = 3'd2,
        PH_STAR    = 3'd3,
        PH_MOD     = 3'd4,
        PH_SPEC    = 3'd5
    } t_phase;

    // Sequencer state.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR,
        ST_ONE,
        ST_DIV,
        ST_SIGN,
        ST_PAD,
        ST_DIG
    } t_state;

    // What one format character turns into.
    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_CHAR,
        JOB_CRLF,
        JOB_NUM
    } t_job;

endpackage

`default_nettype wire

FILE: sv/pnf_if.sv
// Valid/ready channel interfaces for format words in and text words out.
`default_nettype none

interface pnf_fmt_if;
    logic                            valid;
    logic                            ready;
    logic [pnf_pkg::CHAR_BITS-1:0]   fmt_char;
    logic [pnf_pkg::ARG_BITS-1:0]    arg_word;

    modport source (output valid, output fmt_char, output arg_word, input ready);
    modport sink   (input valid, input fmt_char, input arg_word, output ready);
endinterface

interface pnf_txt_if;
    logic                            valid;
    logic                            ready;
    logic [pnf_pkg::CHAR_BITS-1:0]   out_char;
    logic                            char_valid;
    logic                            arg_taken;
    logic                            last;

    modport source (output valid, output out_char, output char_valid,
                    output arg_taken, output last, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input arg_taken, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/printf_number_formatter.sv
// Top level of the printf-style integer formatter: parser, shared divider and emit sequencer.
//
// Usage: the source offers one format character with the current argument word on
// i_fmt; the block answers with one or more text words on o_txt. The last word of
// each item has last set, the first has arg_taken set if the argument was consumed,
// and an item that makes no text gives one word with char_valid low.
// Flow: an accepted plain character goes to ST_ONE, which loads it into the output
// register, and the sequencer then returns to idle for the next item; a newline first
// passes ST_CR, which emits CR before the LF. A numeric conversion runs a shared divider
// that retires eight quotient bits per cycle, one digit per full pass over the word,
// then emits the sign if negative, the fill words and the digits in that order.
// i_fmt.ready is high only while the sequencer is idle; one item is in work at a time.
// The output register holds each word until o_txt.ready; the sequencer waits on it
// while the receiver stalls, and nothing is dropped.
// Reset (synchronous, active low) returns the parser to plain text and empties the
// output register; the digit store needs no clearing since each digit is written
// before it is read.
`default_nettype none

module printf_number_formatter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pnf_fmt_if.sink    i_fmt,
    pnf_txt_if.source  o_txt
);

    // Parser state.
    pnf_pkg::t_state                      r_state,  n_state;
    pnf_pkg::t_phase                      r_phase,  n_phase;
    logic [pnf_pkg::WORD_BITS-1:0]        r_held,   n_held;
    logic [pnf_pkg::CHAR_BITS-1:0]        r_pad,    n_pad;
    logic [pnf_pkg::WIDTH_BITS-1:0]       r_width,  n_width;

    // Conversion working state.
    logic [pnf_pkg::WIDTH_BITS-1:0]       r_padcnt, n_padcnt;
    logic [pnf_pkg::CNT_BITS-1:0]         r_cnt,    n_cnt;
    logic [pnf_pkg::Q_BITS-1:0]           r_q,      n_q;
    logic [pnf_pkg::DIGIT_BITS-1:0]       r_rem,    n_rem;
    logic [pnf_pkg::STEP_CNT_BITS-1:0]    r_step,   n_step;
    logic [pnf_pkg::BASE_BITS-1:0]        r_base,   n_base;
    logic                                 r_upper,  n_upper;
    logic                                 r_neg,    n_neg;
    logic [pnf_pkg::CHAR_BITS-1:0]        r_char,   n_char;
    logic                                 r_cv,     n_cv;
    logic                                 r_taken,  n_taken;
    logic [pnf_pkg::DIGIT_BITS-1:0]       r_digits [pnf_pkg::DIGIT_SLOTS];

    // Output register.
    logic                                 r_ovalid, n_ovalid;
    logic [pnf_pkg::CHAR_BITS-1:0]        r_ochar,  n_ochar;
    logic                                 r_ocv,    n_ocv;
    logic                                 r_otaken, n_otaken;
    logic                                 r_olast,  n_olast;

    // Parser outputs.
    pnf_pkg::t_phase                      p_phase;
    logic [pnf_pkg::WORD_BITS-1:0]        p_held;
    logic [pnf_pkg::CHAR_BITS-1:0]        p_pad;
    logic [pnf_pkg::WIDTH_BITS-1:0]       p_width;
    logic                                 p_taken;
    pnf_pkg::t_job                        p_job;
    logic [pnf_pkg::CHAR_BITS-1:0]        p_char;
    logic [pnf_pkg::BASE_BITS-1:0]        p_base;
    logic                                 p_upper;
    logic                                 p_neg;
    logic [pnf_pkg::WORD_BITS-1:0]        p_mag;
    logic                                 do_ws;
    logic                                 do_ms;
    logic                                 mod_ok;
    logic                                 do_conv;
    logic [pnf_pkg::CHAR_BITS-1:0]        fc;
    logic [pnf_pkg::WIDTH_BITS-1:0]       star_width;

    // Divider and emit signals.
    logic [pnf_pkg::Q_BITS-1:0]           div_q;
    logic [pnf_pkg::DIGIT_BITS-1:0]       div_rem;
    logic [pnf_pkg::STEP_BITS-1:0]        d_bits;
    logic [pnf_pkg::DIGIT_BITS-1:0]       d_rem;
    logic [pnf_pkg::DIGIT_BITS:0]         d_trial;
    logic                                 dig_we;
    logic                                 slot_free;
    logic [pnf_pkg::CNT_BITS-1:0]         cnt_m1;
    logic [pnf_pkg::DIGIT_BITS-1:0]       rd_digit;
    logic [pnf_pkg::CHAR_BITS-1:0]        dig_char;
    logic                                 emit;
    logic [pnf_pkg::CHAR_BITS-1:0]        e_char;
    logic                                 e_cv;
    logic                                 e_last;

    assign fc         = i_fmt.fmt_char;
    assign slot_free  = !r_ovalid || o_txt.ready;
    assign star_width = (i_fmt.arg_word > pnf_pkg::ARG_BITS'(pnf_pkg::MAX_WIDTH))
                      ? pnf_pkg::WIDTH_BITS'(pnf_pkg::MAX_WIDTH)
                      : i_fmt.arg_word[pnf_pkg::WIDTH_BITS-1:0];

    // Format parser: works out the next phase and the job for the offered character.
    always_comb begin
        p_phase = r_phase;
        p_held  = r_held;
        p_pad   = r_pad;
        p_width = r_width;
        p_taken = 1'b0;
        p_job   = pnf_pkg::JOB_NONE;
        p_char  = pnf_pkg::CH_NUL;
        p_base  = pnf_pkg::BASE_DEC;
        p_upper = 1'b0;
        p_neg   = 1'b0;
        do_ws   = 1'b0;
        do_ms   = 1'b0;
        mod_ok  = 1'b1;
        do_conv = 1'b0;

        case (r_phase)
            pnf_pkg::PH_PLAIN: begin
                if (fc == pnf_pkg::CH_PERCENT) begin
                    p_phase = pnf_pkg::PH_PERCENT;
                end else if (fc == pnf_pkg::CH_LF) begin
                    p_job = pnf_pkg::JOB_CRLF;
                end else if (fc != pnf_pkg::CH_NUL) begin
                    p_job  = pnf_pkg::JOB_CHAR;
                    p_char = fc;
                end
            end
            pnf_pkg::PH_PERCENT: begin
                if (fc == pnf_pkg::CH_PERCENT) begin
                    p_job   = pnf_pkg::JOB_CHAR;
                    p_char  = pnf_pkg::CH_PERCENT;
                    p_phase = pnf_pkg::PH_PLAIN;
                end else begin
                    p_held  = pnf_pkg::WORD_BITS'(i_fmt.arg_word);
                    p_taken = 1'b1;
                    p_width = '0;
                    if (fc inside {[pnf_pkg::CH_ONE:pnf_pkg::CH_NINE]}) begin
                        p_pad   = pnf_pkg::CH_SPACE;
                        p_width = pnf_pkg::WIDTH_BITS'(fc[3:0]);
                        p_phase = pnf_pkg::PH_MOD;
                    end else if (fc inside {pnf_pkg::CH_SPACE, pnf_pkg::CH_ZERO}) begin
                        p_pad   = fc;
                        p_phase = pnf_pkg::PH_FLAGGED;
                    end else if (fc == pnf_pkg::CH_DOT) begin
                        p_pad   = pnf_pkg::CH_ZERO;
                        p_phase = pnf_pkg::PH_FLAGGED;
                    end else begin
                        p_pad = pnf_pkg::CH_SPACE;
                        do_ws = 1'b1;
                    end
                end
            end
            pnf_pkg::PH_FLAGGED: begin
                do_ws = 1'b1;
            end
            pnf_pkg::PH_STAR: begin
                p_width = star_width;
                p_taken = 1'b1;
                do_ms   = 1'b1;
            end
            pnf_pkg::PH_MOD: begin
                do_ms = 1'b1;
            end
            pnf_pkg::PH_SPEC: begin
                do_ms  = 1'b1;
                mod_ok = 1'b0;
            end
            default: begin
                p_phase = pnf_pkg::PH_PLAIN;
            end
        endcase

        // Width digit, star, or fall through to modifier/spec.
        if (do_ws) begin
            if (fc inside {[pnf_pkg::CH_ONE:pnf_pkg::CH_NINE]}) begin
                p_width = pnf_pkg::WIDTH_BITS'(fc[3:0]);
                p_phase = pnf_pkg::PH_MOD;
            end else if (fc == pnf_pkg::CH_STAR) begin
                p_phase = pnf_pkg::PH_STAR;
            end else begin
                do_ms = 1'b1;
            end
        end

        // Length modifier, or the conversion itself.
        if (do_ms) begin
            if (mod_ok && (fc inside {pnf_pkg::CH_H, pnf_pkg::CH_L})) begin
                p_phase = pnf_pkg::PH_SPEC;
            end else begin
                p_phase = pnf_pkg::PH_PLAIN;
                do_conv = 1'b1;
            end
        end

        // Pick base, sign handling and output case for the specifier.
        if (do_conv) begin
            case (fc)
                pnf_pkg::CH_D, pnf_pkg::CH_I: begin
                    p_job  = pnf_pkg::JOB_NUM;
                    p_neg  = p_held[pnf_pkg::WORD_BITS-1];
                end
                pnf_pkg::CH_U: begin
                    p_job  = pnf_pkg::JOB_NUM;
                end
                pnf_pkg::CH_O: begin
                    p_job  = pnf_pkg::JOB_NUM;
                    p_base = pnf_pkg::BASE_OCT;
                end
                pnf_pkg::CH_X, pnf_pkg::CH_UP_X: begin
                    p_job   = pnf_pkg::JOB_NUM;
                    p_base  = pnf_pkg::BASE_HEX;
                    p_upper = (fc == pnf_pkg::CH_UP_X);
                end
                pnf_pkg::CH_C: begin
                    p_job  = pnf_pkg::JOB_CHAR;
                    p_char = p_held[pnf_pkg::CHAR_BITS-1:0];
                end
                default: begin
                    p_job = pnf_pkg::JOB_NONE;
                end
            endcase
        end

        p_mag = p_neg ? (pnf_pkg::WORD_BITS'(0) - p_held) : p_held;
    end

    // Shared divider: eight restoring steps per cycle on a narrow remainder.
    always_comb begin
        d_rem   = r_rem;
        d_bits  = '0;
        d_trial = '0;
        for (int i = pnf_pkg::STEP_BITS - 1; i >= 0; i--) begin
            d_trial = {d_rem, r_q[pnf_pkg::Q_BITS - pnf_pkg::STEP_BITS + i]};
            if (d_trial >= r_base) begin
                d_trial   = d_trial - r_base;
                d_bits[i] = 1'b1;
            end
            d_rem = d_trial[pnf_pkg::DIGIT_BITS-1:0];
        end
        div_q   = (r_q << pnf_pkg::STEP_BITS) | pnf_pkg::Q_BITS'(d_bits);
        div_rem = d_rem;
    end

    // Digit readout, most significant stored digit first.
    assign cnt_m1   = r_cnt - pnf_pkg::CNT_BITS'(1);
    assign rd_digit = r_digits[cnt_m1[pnf_pkg::IDX_BITS-1:0]];
    assign dig_char = (rd_digit > 4'd9)
                    ? (pnf_pkg::CHAR_BITS'(rd_digit)
                       + (r_upper ? pnf_pkg::UPPER_OFS : pnf_pkg::LOWER_OFS))
                    : (pnf_pkg::CHAR_BITS'(rd_digit) + pnf_pkg::CH_ZERO);

    // Sequencer: next state and the word to emit.
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_held   = r_held;
        n_pad    = r_pad;
        n_width  = r_width;
        n_padcnt = r_padcnt;
        n_cnt    = r_cnt;
        n_q      = r_q;
        n_rem    = r_rem;
        n_step   = r_step;
        n_base   = r_base;
        n_upper  = r_upper;
        n_neg    = r_neg;
        n_char   = r_char;
        n_cv     = r_cv;
        n_taken  = r_taken;
        dig_we   = 1'b0;
        emit     = 1'b0;
        e_char   = pnf_pkg::CH_NUL;
        e_cv     = 1'b1;
        e_last   = 1'b0;

        case (r_state)
            pnf_pkg::ST_IDLE: begin
                if (i_fmt.valid) begin
                    n_phase = p_phase;
                    n_held  = p_held;
                    n_pad   = p_pad;
                    n_width = p_width;
                    n_taken = p_taken;
                    case (p_job)
                        pnf_pkg::JOB_CHAR: begin
                            n_char  = p_char;
                            n_cv    = 1'b1;
                            n_state = pnf_pkg::ST_ONE;
                        end
                        pnf_pkg::JOB_CRLF: begin
                            n_char  = pnf_pkg::CH_LF;
                            n_cv    = 1'b1;
                            n_state = pnf_pkg::ST_CR;
                        end
                        pnf_pkg::JOB_NUM: begin
                            n_q      = pnf_pkg::Q_BITS'(p_mag);
                            n_rem    = '0;
                            n_step   = '0;
                            n_cnt    = '0;
                            n_base   = p_base;
                            n_upper  = p_upper;
                            n_neg    = p_neg;
                            n_padcnt = p_width;
                            n_state  = pnf_pkg::ST_DIV;
                        end
                        default: begin
                            n_char  = pnf_pkg::CH_NUL;
                            n_cv    = 1'b0;
                            n_state = pnf_pkg::ST_ONE;
                        end
                    endcase
                end
            end
            pnf_pkg::ST_CR: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_char  = pnf_pkg::CH_CR;
                    n_state = pnf_pkg::ST_ONE;
                end
            end
            pnf_pkg::ST_ONE: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_char  = r_char;
                    e_cv    = r_cv;
                    e_last  = 1'b1;
                    n_state = pnf_pkg::ST_IDLE;
                end
            end
            pnf_pkg::ST_DIV: begin
                n_q   = div_q;
                n_rem = div_rem;
                if (r_step == pnf_pkg::STEP_CNT_BITS'(pnf_pkg::DIV_CYCLES - 1)) begin
                    // A digit is done: store it and decide whether another follows.
                    dig_we = 1'b1;
                    n_cnt  = r_cnt + pnf_pkg::CNT_BITS'(1);
                    n_step = '0;
                    n_rem  = '0;
                    if ((div_q == '0)
                        || (r_cnt == pnf_pkg::CNT_BITS'(pnf_pkg::DIGIT_SLOTS - 1))) begin
                        n_state = r_neg ? pnf_pkg::ST_SIGN : pnf_pkg::ST_PAD;
                    end
                end else begin
                    n_step = r_step + pnf_pkg::STEP_CNT_BITS'(1);
                end
            end
            pnf_pkg::ST_SIGN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_char  = pnf_pkg::CH_MINUS;
                    n_state = pnf_pkg::ST_PAD;
                end
            end
            pnf_pkg::ST_PAD: begin
                if (pnf_pkg::CMP_BITS'(r_padcnt) > pnf_pkg::CMP_BITS'(r_cnt)) begin
                    if (slot_free) begin
                        emit     = 1'b1;
                        e_char   = r_pad;
                        n_padcnt = r_padcnt - pnf_pkg::WIDTH_BITS'(1);
                    end
                end else begin
                    n_state = pnf_pkg::ST_DIG;
                end
            end
            pnf_pkg::ST_DIG: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_char = dig_char;
                    e_last = (r_cnt == pnf_pkg::CNT_BITS'(1));
                    n_cnt  = cnt_m1;
                    if (r_cnt == pnf_pkg::CNT_BITS'(1)) begin
                        n_state = pnf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pnf_pkg::ST_IDLE;
            end
        endcase

        // Output register: load on emit, drain when the receiver takes the word.
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_ocv    = r_ocv;
        n_otaken = r_otaken;
        n_olast  = r_olast;
        if (emit) begin
            n_ovalid = 1'b1;
            n_ochar  = e_char;
            n_ocv    = e_cv;
            n_otaken = r_taken;
            n_olast  = e_last;
            n_taken  = 1'b0;
        end else if (o_txt.ready) begin
            n_ovalid = 1'b0;
        end
    end

    // Control and parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pnf_pkg::ST_IDLE;
            r_phase  <= pnf_pkg::PH_PLAIN;
            r_held   <= '0;
            r_pad    <= '0;
            r_width  <= '0;
            r_padcnt <= '0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_taken  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_pad    <= n_pad;
            r_width  <= n_width;
            r_padcnt <= n_padcnt;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_taken  <= n_taken;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_base   <= n_base;
        r_upper  <= n_upper;
        r_neg    <= n_neg;
        r_char   <= n_char;
        r_cv     <= n_cv;
        r_ochar  <= n_ochar;
        r_ocv    <= n_ocv;
        r_otaken <= n_otaken;
        r_olast  <= n_olast;
        if (dig_we) begin
            r_digits[r_cnt[pnf_pkg::IDX_BITS-1:0]] <= div_rem;
        end
    end

    // Channel outputs.
    assign i_fmt.ready      = (r_state == pnf_pkg::ST_IDLE);
    assign o_txt.valid      = r_ovalid;
    assign o_txt.out_char   = r_ochar;
    assign o_txt.char_valid = r_ocv;
    assign o_txt.arg_taken  = r_otaken;
    assign o_txt.last       = r_olast;

endmodule

`default_nettype wire
